// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_CHK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ----- src/smam_pkg.sv -----
`default_nettype none

package smam_pkg;

    localparam int MAX_N  = 8;    // largest matrix size
    localparam int DEPTH  = MAX_N * MAX_N;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW     = $clog2(MAX_N + 1);

    localparam int DATA_W = 16;   // matrix element
    localparam int SUM_W  = 17;   // A + B element
    localparam int MULT_W = 32;   // one A * B term
    localparam int PROD_W = 35;   // accumulated dot product
    localparam int IDX_W  = 3;    // row / column index on the output
    localparam int SIZE_W = 4;    // matrix size register

    // Which store an element goes to
    typedef enum logic {
        SEL_A = 1'b0,
        SEL_B = 1'b1
    } t_store_sel;

    // Classification of one loaded element
    typedef struct packed {
        t_store_sel sel;
        logic       last;   // element completes the load
    } t_item_ctl;

    localparam int CTL_W = $bits(t_item_ctl);

    // queue entry: element, classification, store address, size
    localparam int EW = DATA_W + CTL_W + AW + NW;

endpackage

`default_nettype wire

// ----- src/smam_ram.sv -----
`default_nettype none

module smam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/smam_front.sv -----
`default_nettype none

module smam_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [smam_pkg::SIZE_W-1:0]   i_matrix_size,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [smam_pkg::DATA_W-1:0]   i_data,
    // queue write side
    output logic                               o_push,
    output logic [smam_pkg::EW-1:0]            o_entry,
    input  wire logic                          i_q_ready
);
    import smam_pkg::*;

    localparam int CW = $clog2(2 * DEPTH + 1);

    logic [CW-1:0] r_cnt;
    logic [NW-1:0] n_eff;
    logic [CW-1:0] nn;
    logic [CW-1:0] two_nn;
    logic [CW-1:0] cnt_eff;
    logic [CW-1:0] cnt_inc;
    logic [AW-1:0] addr;
    t_item_ctl     ctl;

    // clamp the size register to 1..MAX_N
    always_comb begin
        if (i_matrix_size == '0) begin
            n_eff = NW'(1);
        end else if (32'(i_matrix_size) > 32'(MAX_N)) begin
            n_eff = NW'(MAX_N);
        end else begin
            n_eff = NW'(i_matrix_size);
        end
    end

    assign nn     = CW'(CW'(n_eff) * CW'(n_eff));
    assign two_nn = CW'({nn, 1'b0});

    // a counter already past the end restarts the load
    assign cnt_eff = (r_cnt >= two_nn) ? '0 : r_cnt;
    assign cnt_inc = CW'(cnt_eff + CW'(1));

    // classify: store, address, end of load
    always_comb begin
        ctl.last = (cnt_inc == two_nn);
        if (cnt_eff >= nn) begin
            ctl.sel = SEL_B;
            addr    = AW'(cnt_eff - nn);
        end else begin
            ctl.sel = SEL_A;
            addr    = AW'(cnt_eff);
        end
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;
    assign o_entry = {i_data, ctl, addr, n_eff};

    // load counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_push) begin
            r_cnt <= ctl.last ? '0 : cnt_inc;
        end
    end

`include "assert_macros.svh"

    `ASSERT_CHK(a_cnt_bound, i_clk, i_rst_n, r_cnt < CW'(2 * DEPTH))
    `ASSERT_NEVER(a_last_is_b, i_clk, i_rst_n,
        o_push && ctl.last && ctl.sel == SEL_A)

endmodule

`default_nettype wire

// ----- src/smam_queue.sv -----
`default_nettype none

module smam_queue #(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // two-entry ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`include "assert_macros.svh"

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && !o_ready)

endmodule

`default_nettype wire

// ----- src/smam_back.sv -----
`default_nettype none

module smam_back (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // queue read side
    input  wire logic                                i_entry_valid,
    input  wire logic [smam_pkg::EW-1:0]             i_entry,
    output logic                                     o_pop,
    // result channel
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic        [smam_pkg::IDX_W-1:0]        o_row_index,
    output logic        [smam_pkg::IDX_W-1:0]        o_col_index,
    output logic signed [smam_pkg::SUM_W-1:0]        o_sum_value,
    output logic signed [smam_pkg::PROD_W-1:0]       o_product_value,
    output logic                                     o_last_result
);
    import smam_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_PUSH
    } t_state;

    t_state r_state;

    // unpacked queue entry
    logic [DATA_W-1:0] e_data;
    t_item_ctl         e_ctl;
    logic [AW-1:0]     e_addr;
    logic [NW-1:0]     e_n;

    // sequencer registers
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_r;
    logic [NW-1:0] r_c;
    logic [NW-1:0] r_k;
    logic [AW-1:0] r_row_base;   // r * n
    logic [AW-1:0] r_kb;         // k * n

    // datapath
    logic                     r_s1_mac;
    logic                     r_s1_sum;
    logic                     r_s2_mac;
    logic signed [MULT_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [PROD_W-1:0] r_acc;

    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;
    logic [AW-1:0]     pos;
    logic [AW-1:0]     a_addr;
    logic [AW-1:0]     b_addr;
    logic              k_end;
    logic              c_end;
    logic              pos_last;
    logic              issue;
    logic              out_free;
    logic              we_a;
    logic              we_b;

    assign {e_data, e_ctl, e_addr, e_n} = i_entry;

    assign o_pop = (r_state == ST_LOAD);
    assign we_a  = o_pop && i_entry_valid && (e_ctl.sel == SEL_A);
    assign we_b  = o_pop && i_entry_valid && (e_ctl.sel == SEL_B);

    // read addresses: A[r][k], B[k][c]; the step after the last k reads A[r][c], B[r][c]
    assign k_end    = (r_k == r_n);
    assign c_end    = (r_c == NW'(r_n - NW'(1)));
    assign pos_last = c_end && (r_r == NW'(r_n - NW'(1)));
    assign pos      = AW'(r_row_base + AW'(r_c));
    assign a_addr   = k_end ? pos : AW'(r_row_base + AW'(r_k));
    assign b_addr   = k_end ? pos : AW'(r_kb + AW'(r_c));
    assign issue    = (r_state == ST_ISSUE);
    assign out_free = !o_valid || i_ready;

    smam_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (e_addr),
        .i_wdata (e_data),
        .i_raddr (a_addr),
        .o_rdata (rd_a)
    );

    smam_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (e_addr),
        .i_wdata (e_data),
        .i_raddr (b_addr),
        .o_rdata (rd_b)
    );

    // multiply stage and sum capture
    always_ff @(posedge i_clk) begin
        if (r_s1_mac) begin
            r_prod <= $signed(rd_a) * $signed(rd_b);
        end
        if (r_s1_sum) begin
            r_sum <= SUM_W'($signed(rd_a)) + SUM_W'($signed(rd_b));
        end
    end

    // sequencer, pipeline valids, accumulator and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_s1_mac <= 1'b0;
            r_s1_sum <= 1'b0;
            r_s2_mac <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_s1_mac <= issue && !k_end;
            r_s1_sum <= issue && k_end;
            r_s2_mac <= r_s1_mac;

            if (r_s2_mac) begin
                r_acc <= r_acc + PROD_W'(r_prod);
            end

            // a new result in the push state replaces the one leaving
            if (o_valid && i_ready && (r_state != ST_PUSH)) begin
                o_valid <= 1'b0;
            end

            unique case (r_state)
                ST_LOAD: begin
                    // last element of B starts the result run
                    if (i_entry_valid && e_ctl.last) begin
                        r_n        <= e_n;
                        r_r        <= '0;
                        r_c        <= '0;
                        r_k        <= '0;
                        r_row_base <= '0;
                        r_kb       <= '0;
                        r_acc      <= '0;
                        r_state    <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (k_end) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_k  <= NW'(r_k + NW'(1));
                        r_kb <= AW'(r_kb + AW'(r_n));
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (out_free) begin
                        o_valid         <= 1'b1;
                        o_row_index     <= IDX_W'(r_r);
                        o_col_index     <= IDX_W'(r_c);
                        o_sum_value     <= r_sum;
                        o_product_value <= r_acc;
                        o_last_result   <= pos_last;
                        r_acc           <= '0;
                        r_k             <= '0;
                        r_kb            <= '0;
                        if (pos_last) begin
                            r_state <= ST_LOAD;
                        end else begin
                            r_state <= ST_ISSUE;
                            if (c_end) begin
                                r_c        <= '0;
                                r_r        <= NW'(r_r + NW'(1));
                                r_row_base <= AW'(r_row_base + AW'(r_n));
                            end else begin
                                r_c <= NW'(r_c + NW'(1));
                            end
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

`include "assert_macros.svh"

    `ASSERT_NEVER(a_push_drained, i_clk, i_rst_n,
        (r_state == ST_PUSH) && (r_s1_mac || r_s1_sum || r_s2_mac))
    `ASSERT_CHK(a_run_ends_last, i_clk, i_rst_n,
        (r_state == ST_PUSH && out_free && pos_last)
        |=> (o_valid && o_last_result && r_state == ST_LOAD))

endmodule

`default_nettype wire

// ----- src/square_matrix_add_multiply.sv -----
// Loading: one element per cycle, while the queue has room, through a two-entry queue
// into the A and B stores. Compute: after the last element of B, each of the n*n results
// takes n+1 store reads on one read port per store, one drain and one output load (which
// waits until the output is free), and new elements wait while the run lasts.
// Reset (synchronous, active low): size register to 1, load counter to zero, queue
// and pipeline empty; store contents are not cleared.
`default_nettype none

module square_matrix_add_multiply (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic        [smam_pkg::SIZE_W-1:0]  i_cfg_matrix_size,
    // element input
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [smam_pkg::DATA_W-1:0]  i_element_value,
    // results
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic        [smam_pkg::IDX_W-1:0]        o_row_index,
    output logic        [smam_pkg::IDX_W-1:0]        o_col_index,
    output logic signed [smam_pkg::SUM_W-1:0]        o_sum_value,
    output logic signed [smam_pkg::PROD_W-1:0]       o_product_value,
    output logic                                     o_last_result
);
    import smam_pkg::*;

    logic [SIZE_W-1:0] r_matrix_size;
    logic              push;
    logic [EW-1:0]     push_entry;
    logic              q_ready;
    logic              q_valid;
    logic              pop;
    logic [EW-1:0]     pop_entry;

    // size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= SIZE_W'(1);
        end else if (i_cfg_we) begin
            r_matrix_size <= i_cfg_matrix_size;
        end
    end

    smam_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_matrix_size (r_matrix_size),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data        (i_element_value),
        .o_push        (push),
        .o_entry       (push_entry),
        .i_q_ready     (q_ready)
    );

    smam_queue #(
        .WIDTH (EW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (pop_entry)
    );

    smam_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry_valid   (q_valid),
        .i_entry         (pop_entry),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_row_index     (o_row_index),
        .o_col_index     (o_col_index),
        .o_sum_value     (o_sum_value),
        .o_product_value (o_product_value),
        .o_last_result   (o_last_result)
    );

endmodule

`default_nettype wire
